// File: hw/rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, register indexes and the window tap type for the 3x3
// Sobel gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 11;
  localparam int FW_W      = 11;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // 3x3 neighborhood taps; the right column is top/mid/bot
  typedef struct packed {
    logic [PIX_W-1:0] lt;
    logic [PIX_W-1:0] lm;
    logic [PIX_W-1:0] lb;
    logic [PIX_W-1:0] ct;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } taps_t;

endpackage

`default_nettype wire

// File: hw/rtl/sobel_line_store.sv
// ----------------------------------------------------------------------------
// sobel_line_store
// Two row buffers (previous row and the row before it). One write and one
// read address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_line_store
  import sobel_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [PIX_W-1:0] wr_prev,
  input  wire logic [PIX_W-1:0] wr_older,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [PIX_W-1:0] rd_prev,
  output logic      [PIX_W-1:0] rd_older
);

  logic [PIX_W-1:0] mem_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_older [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prev[wr_addr]  <= wr_prev;
      mem_older[wr_addr] <= wr_older;
    end
  end

  always_ff @(posedge clk) begin
    rd_prev  <= mem_prev[rd_addr];
    rd_older <= mem_older[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sobel_kernel.sv
// ----------------------------------------------------------------------------
// sobel_kernel
// Sobel x and y gradients from one 3x3 window, weights 1,2,1.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_kernel
  import sobel_pkg::*;
(
  input  wire taps_t             taps,
  output logic      [GRAD_W-1:0] grad_x,
  output logic      [GRAD_W-1:0] grad_y
);

  // each weighted sum is at most 1020, so sums fit and differences wrap in 11 bits
  logic [GRAD_W-1:0] right_sum, left_sum, bot_sum, top_sum;

  always_comb begin
    right_sum = GRAD_W'(taps.top) + (GRAD_W'(taps.mid) << 1) + GRAD_W'(taps.bot);
    left_sum  = GRAD_W'(taps.lt)  + (GRAD_W'(taps.lm)  << 1) + GRAD_W'(taps.lb);
    bot_sum   = GRAD_W'(taps.lb)  + (GRAD_W'(taps.cb)  << 1) + GRAD_W'(taps.bot);
    top_sum   = GRAD_W'(taps.lt)  + (GRAD_W'(taps.ct)  << 1) + GRAD_W'(taps.top);
    grad_x    = right_sum - left_sum;
    grad_y    = bot_sum - top_sum;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sobel_3x3_gradient_top.sv
// ----------------------------------------------------------------------------
// sobel_3x3_gradient_top
// 3x3 Sobel gradient over a raster pixel stream; one result per interior
// window center, tlast on the frame's last result.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata[7:0] pixel
//  m_axis    out  tdata[10:0] grad_x, [21:11] grad_y, [23:22] zero; tlast frame_end
//  cfg       in   cfg_index 0 frame_width, 1 frame_height; cfg_data
//
//  One pixel per clock. The line-store read for the next column is issued the
//  cycle before, so a result is written to the output register, or to the skid
//  entry if the output stalls, as its pixel is taken. The two-entry output lets
//  one more pixel in during an output stall; input stalls when both are full,
//  while a register write is offered, and during rst.
//  rst clears counters, window and output valid; line stores are not cleared.
//  A write to frame_width or frame_height restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_3x3_gradient_top
  import sobel_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [OUT_DAT_W-1:0] m_axis_tdata,   // [10:0] grad_x, [21:11] grad_y
  output logic                      m_axis_tlast,   // frame_end
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [COL_W-1:0] width_last, width_last_next;
  logic [ROW_W-1:0] height_last, height_last_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] win [6];

  logic             cfg_fire, cfg_restart, in_fire, produce, last_col, last_row;
  logic [PIX_W-1:0] top_q, mid_q, pixel;
  logic [FW_W-1:0]  fw_raw;
  taps_t            taps;
  logic [GRAD_W-1:0] grad_x, grad_y;

  logic             skid_valid, skid_last;
  logic [2*GRAD_W-1:0] skid_data;
  logic             out_last;
  logic [2*GRAD_W-1:0] out_data;

  assign cfg_ready     = !rst;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign cfg_restart   = cfg_fire && (cfg_index == REG_FRAME_WIDTH ||
                                      cfg_index == REG_FRAME_HEIGHT);
  assign s_axis_tready = !rst && !skid_valid && !cfg_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pixel         = s_axis_tdata;

  assign last_col = column_count >= width_last;
  assign last_row = row_count >= height_last;
  assign produce  = in_fire && (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));

  // effective limits, stored as last column / last row index
  always_comb begin
    fw_raw = cfg_data[FW_W-1:0];
    if (fw_raw < FW_W'(3)) begin
      width_last_next = COL_W'(2);
    end else if (fw_raw > FW_W'(MAX_WIDTH)) begin
      width_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last_next = COL_W'(fw_raw - FW_W'(1));
    end
    if (cfg_data < ROW_W'(3)) begin
      height_last_next = ROW_W'(2);
    end else begin
      height_last_next = cfg_data - ROW_W'(1);
    end
  end

  always_comb begin
    priority if (cfg_restart) begin
      column_count_next = '0;
    end else if (in_fire) begin
      column_count_next = last_col ? '0 : column_count + COL_W'(1);
    end else begin
      column_count_next = column_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= COL_W'(640 - 1);
      height_last <= ROW_W'(480 - 1);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_last  <= width_last_next;
        REG_FRAME_HEIGHT: height_last <= height_last_next;
        default: ;
      endcase
    end
  end

  // a write to frame_width or frame_height restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (in_fire) begin
      column_count <= column_count_next;
      if (last_col) begin
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_q;
      win[4] <= mid_q;
      win[5] <= pixel;
    end
  end

  // read address tracks the column of the next pixel; it never equals the
  // column written in the same cycle since width is at least 3
  sobel_line_store u_line_store (
    .clk      (clk),
    .wr_en    (in_fire),
    .wr_addr  (column_count),
    .wr_prev  (pixel),
    .wr_older (mid_q),
    .rd_addr  (column_count_next),
    .rd_prev  (mid_q),
    .rd_older (top_q)
  );

  always_comb begin
    taps.lt  = win[0];
    taps.lm  = win[1];
    taps.lb  = win[2];
    taps.ct  = win[3];
    taps.cb  = win[5];
    taps.top = top_q;
    taps.mid = mid_q;
    taps.bot = pixel;
  end

  sobel_kernel u_kernel (
    .taps   (taps),
    .grad_x (grad_x),
    .grad_y (grad_y)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= skid_valid || produce;
      skid_valid    <= 1'b0;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_last <= skid_last;
      end else begin
        out_data <= {grad_y, grad_x};
        out_last <= last_col && last_row;
      end
    end else if (produce) begin
      skid_data <= {grad_y, grad_x};
      skid_last <= last_col && last_row;
    end
  end

  assign m_axis_tdata = {(OUT_DAT_W - 2*GRAD_W)'(0), out_data};
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

// File: hw/rtl/sobel_checker.sv
// ----------------------------------------------------------------------------
// sobel_checker
// Port-level checks for the Sobel gradient block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_checker
  import sobel_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OUT_DAT_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a new result only follows an accepted pixel
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without a pixel");

  // gradients stay inside +/-1020
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[10:0]) >= -11'sd1020) &&
                      ($signed(m_axis_tdata[10:0]) <= 11'sd1020) &&
                      ($signed(m_axis_tdata[21:11]) >= -11'sd1020) &&
                      ($signed(m_axis_tdata[21:11]) <= 11'sd1020))
    else $error("gradient out of range");

  // padding bits are zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DAT_W-1:2*GRAD_W] == '0)
    else $error("nonzero tdata padding");

endmodule

bind sobel_3x3_gradient_top sobel_checker u_sobel_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: sim/sobel_3x3_gradient_checker.sv
// ----------------------------------------------------------------------------
// sobel_3x3_gradient_checker
// Watches the pixel, gradient and register channels of the Sobel block. It
// keeps its own line stores, window and counters, works out the gradient
// each accepted pixel should produce and compares every accepted result,
// in order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_3x3_gradient_checker
  import sobel_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [OUT_DAT_W-1:0] m_axis_tdata,   // [10:0] grad_x, [21:11] grad_y
  input  wire logic                 m_axis_tlast,   // frame_end
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output int                        pending,
  output int                        errors,
  output int                        n_grads,
  output int                        n_frame_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     frame_end;
  } gradient_t;

  gradient_t        grad_q[$];
  bit [PIX_W-1:0]   row_above  [MAX_WIDTH];  // previous row
  bit [PIX_W-1:0]   row_above2 [MAX_WIDTH];  // row before that
  bit [PIX_W-1:0]   col_hist [6];            // [0..2] older column n/c/s, [3..5] newer
  logic [FW_W-1:0]  width_reg;
  logic [ROW_W-1:0] height_reg;
  int               x_pos;
  int               y_pos;

  task automatic restart_frame();
    x_pos = 0;
    y_pos = 0;
    foreach (col_hist[i]) col_hist[i] = '0;
  endtask

  task automatic report_failure(input string msg);
    if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : track
    int        w_eff, h_eff, slot;
    int        n_tap, c_tap, s_tap, left_n, left_c, left_s, mid_n, mid_s;
    int        dx, dy;
    gradient_t want;
    logic [GRAD_W-1:0] got_x, got_y;
    if (rst) begin
      width_reg  = FW_W'(640);
      height_reg = ROW_W'(480);
      restart_frame();
      grad_q.delete();
    end else begin
      // any write to a known register restarts the frame
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data[FW_W-1:0];
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        w_eff = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h_eff = (height_reg < 3) ? 3 : int'(height_reg);
        slot  = (x_pos < MAX_WIDTH) ? x_pos : MAX_WIDTH - 1;
        n_tap  = row_above2[slot];
        c_tap  = row_above[slot];
        s_tap  = s_axis_tdata;
        left_n = col_hist[0];
        left_c = col_hist[1];
        left_s = col_hist[2];
        mid_n  = col_hist[3];
        mid_s  = col_hist[5];
        if (y_pos >= 2 && x_pos >= 2) begin
          dx = (n_tap + 2 * c_tap + s_tap) - (left_n + 2 * left_c + left_s);
          dy = (left_s + 2 * mid_s + s_tap) - (left_n + 2 * mid_n + n_tap);
          want.gx        = dx[GRAD_W-1:0];
          want.gy        = dy[GRAD_W-1:0];
          want.frame_end = (x_pos >= w_eff - 1) && (y_pos >= h_eff - 1);
          grad_q.push_back(want);
        end
        row_above2[slot] = c_tap[PIX_W-1:0];
        row_above[slot]  = s_axis_tdata;
        col_hist[0] = col_hist[3];
        col_hist[1] = col_hist[4];
        col_hist[2] = col_hist[5];
        col_hist[3] = n_tap[PIX_W-1:0];
        col_hist[4] = c_tap[PIX_W-1:0];
        col_hist[5] = s_axis_tdata;
        if (x_pos >= w_eff - 1) begin
          x_pos = 0;
          y_pos = (y_pos >= h_eff - 1) ? 0 : y_pos + 1;
        end else begin
          x_pos++;
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got_x = m_axis_tdata[GRAD_W-1:0];
        got_y = m_axis_tdata[2*GRAD_W-1:GRAD_W];
        if (grad_q.size() == 0) begin
          report_failure($sformatf("unexpected result: tdata 0x%h tlast %b",
                                   m_axis_tdata, m_axis_tlast));
        end else begin
          want = grad_q.pop_front();
          n_grads++;
          if (got_x !== want.gx)
            report_failure($sformatf("grad_x %0d, expected %0d", $signed(got_x), want.gx));
          if (got_y !== want.gy)
            report_failure($sformatf("grad_y %0d, expected %0d", $signed(got_y), want.gy));
          if (m_axis_tlast !== want.frame_end)
            report_failure($sformatf("frame_end %b, expected %b", m_axis_tlast,
                                     want.frame_end));
          if (m_axis_tdata[OUT_DAT_W-1:2*GRAD_W] !== '0)
            report_failure($sformatf("tdata pad bits 0x%h, expected zero",
                                     m_axis_tdata[OUT_DAT_W-1:2*GRAD_W]));
          if (want.frame_end) n_frame_ends++;
        end
      end
    end
    pending <= grad_q.size();
  end

endmodule

`default_nettype wire

// File: sim/tb_sobel_3x3_gradient_top.sv
// ----------------------------------------------------------------------------
// tb_sobel_3x3_gradient_top
// Drives pixel frames and register writes into the Sobel gradient block with
// random gaps on both channels. A short directed part hits the gradient
// extremes and odd register values; random frames of many shapes follow,
// with restarts mid-frame, unknown register indexes and one very tall frame.
// The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sobel_3x3_gradient_top
  import sobel_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 12;
  localparam int RAND_PIXELS   = 850;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_WAIT      = 5000;
  localparam int LIMIT_NS      = 30_000_000;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata  = '0;     // [7:0] pixel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DAT_W-1:0] m_axis_tdata;           // [10:0] grad_x, [21:11] grad_y
  logic                 m_axis_tlast;           // frame_end
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;

  int pending, errors, n_grads, n_frame_ends;
  int n_pixels;
  int n_writes;
  bit src_idle;
  bit snk_idle   = 1'b0;
  int stall_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sobel_3x3_gradient_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sobel_3x3_gradient_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .errors        (errors),
    .n_grads       (n_grads),
    .n_frame_ends  (n_frame_ends)
  );

  // mostly back-to-back, sometimes a short gap, rarely a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom);
  endfunction

  // sink backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (snk_idle && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // valid stays high between back-to-back items
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    n_pixels++;
  endtask

  // register writes only once the block has drained
  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", pending);
    $display("sobel_3x3_gradient_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int wv, hv, frame_len, npx, poke_at, rand_px, wait_cnt;
    rand_px  = 0;
    src_idle = 1'b1;
    repeat (3) @(posedge clk);
    rst      <= 1'b0;
    snk_idle <= 1'b1;

    // columns 0,255,255,0: grad_x +1020 then -1020; upper data bits ignored
    poke_reg(REG_FRAME_WIDTH, 16'hF804);
    poke_reg(REG_FRAME_HEIGHT, 16'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) send_pixel((c == 1 || c == 2) ? 8'hFF : 8'h00);
      // unknown index mid-frame must leave the frame running
      if (r == 0) poke_reg(8'hFE, 16'hFFFF);
    end
    // width below range acts as 3; rows 0,255,255,0 give grad_y +1020 then -1020
    poke_reg(REG_FRAME_WIDTH, 16'd2);
    poke_reg(REG_FRAME_HEIGHT, 16'd4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 3; c++) send_pixel((r == 1 || r == 2) ? 8'hFF : 8'h00);

    // tallest setting, run a stretch of it then restart
    src_idle = ($urandom_range(0, 1) != 0);
    poke_reg(REG_FRAME_WIDTH, CFG_DAT_W'($urandom_range(3, 8)));
    poke_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    repeat (200) send_pixel(random_pixel());

    // small random frames, several per setting, some cut short
    while (rand_px < RAND_PIXELS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle <= ($urandom_range(0, 3) != 0);
      wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      poke_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(wv)});
      poke_reg(REG_FRAME_HEIGHT, 16'(hv));
      frame_len = (wv < 3 ? 3 : wv) * (hv < 3 ? 3 : hv);
      npx = $urandom_range(1, 3) * frame_len;
      if ($urandom_range(0, 3) == 0) npx += $urandom_range(1, frame_len - 1);
      poke_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, npx - 1) : -1;
      for (int i = 0; i < npx; i++) begin
        if (i == poke_at) poke_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom));
        send_pixel(random_pixel());
      end
      rand_px += npx;
    end

    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    do begin
      @(posedge clk);
      wait_cnt++;
    end while (pending != 0 && wait_cnt < END_WAIT);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels and %0d register writes (widths up to 12, heights up to 65535)",
             n_pixels, n_writes);
    $display("%0d gradients compared, %0d frame ends", n_grads, n_frame_ends);
    if (errors == 0 && pending == 0) begin
      $display("sobel_3x3_gradient_top verification clean");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("sobel_3x3_gradient_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
